// ----- design/itt_pkg.sv -----
// ----------------------------------------------------------------------------
// itt_pkg: shared definitions for the IR text tokenizer
// Token kinds, value class codes, keyword spellings and the records that travel
// from the byte scanner to the token formatter.
// ----------------------------------------------------------------------------
package itt_pkg;

	localparam int MAX_KW      = 18;
	localparam int KW_IDX_W    = 5;
	localparam int KW_BITS     = 8 * MAX_KW;
	localparam int LIT_LIMIT   = 32;
	localparam int POS_W       = 32;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int NUM_KW      = 101;

	localparam logic [6:0] K_EOF      = 7'd0;
	localparam logic [6:0] K_ERR      = 7'd1;
	localparam logic [6:0] K_LPAREN   = 7'd2;
	localparam logic [6:0] K_RPAREN   = 7'd3;
	localparam logic [6:0] K_LBRACE   = 7'd4;
	localparam logic [6:0] K_RBRACE   = 7'd5;
	localparam logic [6:0] K_LBRACK   = 7'd6;
	localparam logic [6:0] K_RBRACK   = 7'd7;
	localparam logic [6:0] K_COMMA    = 7'd8;
	localparam logic [6:0] K_EQUAL    = 7'd9;
	localparam logic [6:0] K_STAR     = 7'd10;
	localparam logic [6:0] K_COLON    = 7'd11;
	localparam logic [6:0] K_LESS     = 7'd12;
	localparam logic [6:0] K_GREATER  = 7'd13;
	localparam logic [6:0] K_ELLIPSIS = 7'd14;
	localparam logic [6:0] K_LOCAL    = 7'd15;
	localparam logic [6:0] K_GLOBAL   = 7'd16;
	localparam logic [6:0] K_INT      = 7'd17;
	localparam logic [6:0] K_FLOAT    = 7'd18;
	localparam logic [6:0] K_STRING   = 7'd19;
	localparam logic [6:0] K_META     = 7'd20;
	localparam logic [6:0] K_ATTR     = 7'd21;
	localparam logic [6:0] K_I1       = 7'd22;
	localparam logic [6:0] K_I8       = 7'd23;
	localparam logic [6:0] K_I16      = 7'd24;
	localparam logic [6:0] K_I32      = 7'd25;
	localparam logic [6:0] K_I64      = 7'd26;
	localparam logic [6:0] K_KW0      = 7'd27;

	localparam logic [1:0] VC_NONE = 2'd0;
	localparam logic [1:0] VC_INT  = 2'd1;
	localparam logic [1:0] VC_HEX  = 2'd2;

	localparam logic [63:0] SAT_CAP = 64'h8000_0000_0000_0000;

	localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KW] = '{
		"define", "declare", "ret", "br", "label", "add", "sub", "mul", "sdiv",
		"srem", "urem", "and", "or", "xor", "shl", "lshr", "ashr", "fadd", "fsub",
		"fmul", "fdiv", "fneg", "icmp", "fcmp", "alloca", "load", "store",
		"getelementptr", "call", "phi", "select", "sext", "zext", "trunc",
		"bitcast", "ptrtoint", "inttoptr", "sitofp", "fptosi", "fpext", "fptrunc",
		"extractvalue", "insertvalue", "unreachable", "to", "align", "nsw", "nuw",
		"inbounds", "nonnull", "noundef", "signext", "zeroext", "nocapture",
		"readonly", "writeonly", "global", "constant", "external", "internal",
		"private", "common", {"linkonce", "_odr"}, {"dso", "_local"},
		{"unnamed", "_addr"}, {"local_", "unnamed", "_addr"}, "type", "opaque",
		"null", "undef",
		"zeroinitializer", "true", "false", "nnan", "ninf", "nsz", "void",
		"float", "double", "ptr", "eq", "ne", "sgt", "sge", "slt", "sle", "ugt",
		"uge", "ult", "ule", "oeq", "one", "ogt", "oge", "olt", "ole", "ord",
		"ueq", "une", "uno", "x"
	};

	typedef struct packed {
		logic [6:0]         kind;
		logic               lookup;
		logic [1:0]         vclass;
		logic               neg;
		logic [63:0]        acc;
		logic [POS_W-1:0]   start;
		logic [POS_W-1:0]   len;
		logic [POS_W-1:0]   line;
		logic [POS_W-1:0]   col;
		logic [KW_BITS-1:0] word;
	} tok_full_t;

	typedef struct packed {
		logic [6:0]       kind;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] len;
		logic [POS_W-1:0] line;
		logic [POS_W-1:0] col;
	} tok_short_t;

	typedef struct packed {
		logic       v0;
		logic       v1;
		tok_full_t  t0;
		tok_short_t t1;
	} qent_t;

	// The key holds the word right-aligned, so the match also checks its length.
	function automatic logic [6:0] kw_kind(input logic [KW_BITS-1:0] key);
		logic [6:0] k;
		k = K_LOCAL;
		for (int i = 0; i < NUM_KW; i++) begin
			if (key == KW_TEXT[i])
				k = K_KW0 + 7'(i);
		end
		if (key == KW_BITS'("i1"))  k = K_I1;
		if (key == KW_BITS'("i8"))  k = K_I8;
		if (key == KW_BITS'("i16")) k = K_I16;
		if (key == KW_BITS'("i32")) k = K_I32;
		if (key == KW_BITS'("i64")) k = K_I64;
		return k;
	endfunction

endpackage

// ----- design/ir_text_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// ir_text_tokenizer_top: streaming tokenizer for textual compiler IR
// Takes one source byte per transaction and delivers tokens with position,
// line, column and literal values.
// ----------------------------------------------------------------------------
// The block accepts one byte per clock cycle while its four-entry token queue
// has room. Each byte yields zero, one or two tokens; the formatter delivers
// one token per cycle while the output is not stalled, so a run of bytes that
// each yield two tokens is paced by the output side. A completed token passes
// through the token queue into the output register. End of text flushes the
// pending token, delivers an end-of-file token and restarts the counters.
module ir_text_tokenizer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  logic [7:0]         text_byte,
	input  logic               end_of_text,
	output logic               tok_valid,
	input  logic               tok_stall,
	output logic [6:0]         token_kind,
	output logic [31:0]        start_offset,
	output logic [31:0]        token_length,
	output logic [31:0]        token_line,
	output logic [31:0]        start_column,
	output logic signed [63:0] integer_value,
	output logic [63:0]        hex_bits,
	output logic               last_of_run
);

	itt_pkg::qent_t ent, head;
	logic push, pop, full, empty, take;

	assign src_stall = full;
	assign take      = src_valid && !full;

	itt_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .text_byte(text_byte),
		.end_of_text(end_of_text), .push(push), .ent(ent)
	);

	itt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(ent), .pop(pop),
		.rdata(head), .full(full), .empty(empty)
	);

	itt_back u_back (
		.clk(clk), .arst_n(arst_n), .have(!empty), .head(head), .pop(pop),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .token_kind(token_kind),
		.start_offset(start_offset), .token_length(token_length),
		.token_line(token_line), .start_column(start_column),
		.integer_value(integer_value), .hex_bits(hex_bits), .last_of_run(last_of_run)
	);

endmodule

// ----- design/itt_front.sv -----
// ----------------------------------------------------------------------------
// itt_front: byte scanner
// Runs the per-byte scan state machine, keeps position, line and column, and
// pushes the tokens each byte completes into the token queue.
// ----------------------------------------------------------------------------
module itt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	output logic                push,
	output itt_pkg::qent_t      ent
);

	localparam logic [4:0] M_IDLE = 5'd0, M_COMMENT = 5'd1, M_DOT1 = 5'd2, M_DOT2 = 5'd3,
		M_DOTID = 5'd4, M_META = 5'd5, M_ATTR = 5'd6, M_SIG0 = 5'd7, M_SIGRUN = 5'd8,
		M_QNAME = 5'd9, M_QNAME_ESC = 5'd10, M_STRING = 5'd11, M_STRING_ESC = 5'd12,
		M_C0 = 5'd13, M_IDENT = 5'd14, M_MINUS = 5'd15, M_ZERO = 5'd16, M_INT = 5'd17,
		M_HEX = 5'd18, M_FRAC = 5'd19, M_EXP0 = 5'd20, M_EXPD = 5'd21;

	localparam int PW = itt_pkg::POS_W;

	logic [PW-1:0] pos_q, line_q, col_q, start_q, sline_q, scol_q;
	logic [4:0]    mode_q;
	logic [63:0]   acc_q;
	logic [1:0]    flags_q;
	logic [7:0]    wbuf_q [itt_pkg::MAX_KW];

	logic [4:0]    n_mode;
	logic [63:0]   n_acc;
	logic [1:0]    n_flags;
	logic          set_start, wr_buf, took, fin;
	logic [4:0]    fmode;
	logic [PW-1:0] rel, cur_len;
	logic [itt_pkg::KW_BITS-1:0] wvec;
	logic [63:0]   acc_dec, acc_hx;
	logic [3:0]    dval, hval;
	logic          b_digit, b_alpha, b_word, b_hex;

	always_comb begin
		for (int k = 0; k < itt_pkg::MAX_KW; k++)
			wvec[(itt_pkg::MAX_KW-1-k)*8 +: 8] = wbuf_q[k];
	end

	assign b_digit = (text_byte >= "0") && (text_byte <= "9");
	assign b_alpha = ((text_byte | 8'h20) >= "a") && ((text_byte | 8'h20) <= "z");
	assign b_word  = b_alpha || b_digit || text_byte == "_" || text_byte == "."
		|| text_byte == "$";
	assign b_hex   = b_digit || (((text_byte | 8'h20) >= "a") && ((text_byte | 8'h20) <= "f"));
	assign dval    = text_byte[3:0];
	assign hval    = b_digit ? text_byte[3:0] : 4'(text_byte[3:0] + 4'd9);

	// Decimal accumulation saturates at 2^63; the limit is (2^63 - d) / 10.
	always_comb begin
		if (acc_q > ((dval == 4'd9) ? 64'd922337203685477579 : 64'd922337203685477580))
			acc_dec = itt_pkg::SAT_CAP;
		else
			acc_dec = (acc_q << 3) + (acc_q << 1) + 64'(dval);
		acc_hx = (acc_q > 64'h0FFF_FFFF_FFFF_FFFF) ? '1 : {acc_q[59:0], hval};
	end

	assign rel     = pos_q - start_q;
	assign cur_len = rel;

	function automatic itt_pkg::tok_full_t fin_tok(input logic [4:0] m, input logic [1:0] fl,
		input logic [PW-1:0] len, input logic [PW-1:0] st, input logic [PW-1:0] ln,
		input logic [PW-1:0] cl, input logic [63:0] acc,
		input logic [itt_pkg::KW_BITS-1:0] w);
		itt_pkg::tok_full_t t;
		t.kind = itt_pkg::K_LOCAL; t.lookup = 1'b0; t.vclass = itt_pkg::VC_NONE;
		t.neg = fl[1]; t.acc = acc; t.start = st; t.len = len; t.line = ln; t.col = cl;
		t.word = w;
		case (m)
			M_DOT1, M_MINUS: t.kind = itt_pkg::K_ERR;
			M_META:          t.kind = itt_pkg::K_META;
			M_ATTR:          t.kind = itt_pkg::K_ATTR;
			M_SIG0, M_SIGRUN, M_QNAME, M_QNAME_ESC:
				t.kind = fl[0] ? itt_pkg::K_GLOBAL : itt_pkg::K_LOCAL;
			M_STRING, M_STRING_ESC: t.kind = itt_pkg::K_STRING;
			M_C0, M_IDENT:   t.lookup = 1'b1;
			M_ZERO, M_INT: begin
				t.kind = itt_pkg::K_INT; t.vclass = itt_pkg::VC_INT;
			end
			M_HEX: begin
				t.kind = itt_pkg::K_FLOAT; t.vclass = itt_pkg::VC_HEX;
			end
			M_FRAC, M_EXP0, M_EXPD: t.kind = itt_pkg::K_FLOAT;
			default: t.kind = itt_pkg::K_LOCAL;
		endcase
		return t;
	endfunction

	always_comb begin
		n_mode = mode_q; n_acc = acc_q; n_flags = flags_q;
		set_start = 1'b0; wr_buf = 1'b0; took = 1'b0; fin = 1'b0;
		fmode = mode_q;
		ent = '0;
		ent.t0 = fin_tok(mode_q, flags_q, cur_len, start_q, sline_q, scol_q, acc_q, wvec);
		ent.t1.start = pos_q; ent.t1.line = line_q; ent.t1.col = col_q;
		ent.t1.len = PW'(1);
		if (end_of_text) begin
			ent.v0 = (mode_q != M_IDLE) && (mode_q != M_COMMENT);
			ent.v1 = 1'b1;
			ent.t1.kind = itt_pkg::K_EOF;
			ent.t1.len = '0;
		end else begin
			if (mode_q != M_IDLE) begin
				case (mode_q)
					M_COMMENT: begin
						took = text_byte != 8'h0A;
						fmode = M_IDLE;
					end
					M_DOT1: begin
						if (text_byte == ".") begin n_mode = M_DOT2; took = 1'b1; end
						else if (b_word) begin n_mode = M_DOTID; took = 1'b1; end
					end
					M_DOT2: begin
						if (text_byte == ".") begin
							ent.v0 = 1'b1;
							ent.t0.kind = itt_pkg::K_ELLIPSIS;
							ent.t0.len = PW'(3);
							n_mode = M_IDLE; took = 1'b1;
						end else if (b_word) begin n_mode = M_DOTID; took = 1'b1; end
					end
					M_DOTID, M_META, M_SIGRUN: took = b_word;
					M_ATTR: took = b_digit;
					M_SIG0: begin
						if (text_byte == 8'h22) begin n_mode = M_QNAME; took = 1'b1; end
						else if (b_word) begin n_mode = M_SIGRUN; took = 1'b1; end
					end
					M_QNAME, M_STRING: begin
						took = 1'b1;
						if (text_byte == 8'h22) begin
							ent.v0 = 1'b1;
							ent.t0.len = rel + PW'(1);
							n_mode = M_IDLE;
						end else if (text_byte == 8'h5C) begin
							n_mode = (mode_q == M_QNAME) ? M_QNAME_ESC : M_STRING_ESC;
						end
					end
					M_QNAME_ESC: begin n_mode = M_QNAME; took = 1'b1; end
					M_STRING_ESC: begin n_mode = M_STRING; took = 1'b1; end
					M_C0: begin
						if (text_byte == 8'h22) begin n_mode = M_STRING; took = 1'b1; end
						else if (b_word) begin
							wr_buf = 1'b1; n_mode = M_IDENT; took = 1'b1;
						end
					end
					M_IDENT: begin
						wr_buf = b_word; took = b_word;
					end
					M_MINUS: begin
						if (b_digit) begin n_acc = acc_dec; n_mode = M_INT; took = 1'b1; end
					end
					M_ZERO, M_INT: begin
						fmode = M_INT;
						if (mode_q == M_ZERO && (text_byte == "x" || text_byte == "X")) begin
							n_mode = M_HEX; took = 1'b1;
						end else if (b_digit) begin
							n_acc = acc_dec; n_mode = M_INT; took = 1'b1;
						end else if (text_byte == ".") begin
							n_mode = M_FRAC; took = 1'b1;
						end else if (text_byte == "e" || text_byte == "E") begin
							n_mode = M_EXP0; took = 1'b1;
						end
					end
					M_HEX: begin
						if (b_hex) begin n_acc = acc_hx; took = 1'b1; end
					end
					M_FRAC: begin
						if (b_digit) took = 1'b1;
						else if (text_byte == "e" || text_byte == "E") begin
							n_mode = M_EXP0; took = 1'b1;
						end
					end
					M_EXP0: begin
						if (text_byte == "+" || text_byte == "-" || b_digit) begin
							n_mode = M_EXPD; took = 1'b1;
						end
					end
					M_EXPD: took = b_digit;
					default: fmode = M_IDLE;
				endcase
				if (!took) begin
					fin = (fmode != M_IDLE) && (fmode != M_COMMENT);
					ent.v0 = fin;
					ent.t0 = fin_tok(fmode, flags_q, cur_len, start_q, sline_q, scol_q,
						acc_q, wvec);
					n_mode = M_IDLE;
				end
			end
			// A byte not taken by the pending token is skipped or begins a comment or token.
			if (mode_q == M_IDLE || !took) begin
				case (text_byte)
					" ", 8'h09, 8'h0D, 8'h0A: n_mode = M_IDLE;
					";": n_mode = M_COMMENT;
					"(": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_LPAREN; end
					")": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_RPAREN; end
					"{": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_LBRACE; end
					"}": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_RBRACE; end
					"[": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_LBRACK; end
					"]": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_RBRACK; end
					",": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_COMMA; end
					"=": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_EQUAL; end
					"*": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_STAR; end
					":": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_COLON; end
					"<": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_LESS; end
					">": begin ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_GREATER; end
					default: begin
						set_start = 1'b1;
						n_acc = '0;
						n_flags = '0;
						n_mode = M_IDLE;
						if (text_byte == ".") n_mode = M_DOT1;
						else if (text_byte == "!") n_mode = M_META;
						else if (text_byte == "#") n_mode = M_ATTR;
						else if (text_byte == "%") n_mode = M_SIG0;
						else if (text_byte == "@") begin n_flags = 2'b01; n_mode = M_SIG0; end
						else if (text_byte == 8'h22) n_mode = M_STRING;
						else if (text_byte == "c") begin wr_buf = 1'b1; n_mode = M_C0; end
						else if (text_byte == "-") begin n_flags = 2'b10; n_mode = M_MINUS; end
						else if (text_byte == "0") n_mode = M_ZERO;
						else if (b_digit) begin n_acc = 64'(dval); n_mode = M_INT; end
						else if (b_alpha || text_byte == "_") begin
							wr_buf = 1'b1; n_mode = M_IDENT;
						end else begin
							ent.v1 = 1'b1; ent.t1.kind = itt_pkg::K_ERR;
						end
					end
				endcase
			end
		end
	end

	assign push = take && (ent.v0 || ent.v1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; line_q <= PW'(1); col_q <= PW'(1);
			start_q <= '0; sline_q <= PW'(1); scol_q <= PW'(1);
			mode_q <= M_IDLE; acc_q <= '0; flags_q <= '0;
		end else if (take) begin
			if (end_of_text) begin
				pos_q <= '0; line_q <= PW'(1); col_q <= PW'(1);
				start_q <= '0; sline_q <= PW'(1); scol_q <= PW'(1);
				mode_q <= M_IDLE; acc_q <= '0; flags_q <= '0;
			end else begin
				pos_q <= pos_q + PW'(1);
				if (text_byte == 8'h0A) begin
					line_q <= line_q + PW'(1); col_q <= PW'(1);
				end else begin
					col_q <= col_q + PW'(1);
				end
				if (set_start) begin
					start_q <= pos_q; sline_q <= line_q; scol_q <= col_q;
				end
				mode_q <= n_mode; acc_q <= n_acc; flags_q <= n_flags;
			end
		end
	end

	// Word bytes land at their offset from the token start; a new token starts at 0.
	always_ff @(posedge clk) begin
		if (take && !end_of_text && wr_buf) begin
			if (set_start)
				wbuf_q[0] <= text_byte;
			else if (rel < PW'(itt_pkg::MAX_KW))
				wbuf_q[rel[itt_pkg::KW_IDX_W-1:0]] <= text_byte;
		end
	end

endmodule

// ----- design/itt_queue.sv -----
// ----------------------------------------------------------------------------
// itt_queue: token queue
// A short first-in first-out queue of per-byte token groups between the
// scanner and the formatter.
// ----------------------------------------------------------------------------
module itt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  itt_pkg::qent_t wdata,
	input  logic           pop,
	output itt_pkg::qent_t rdata,
	output logic           full,
	output logic           empty
);

	itt_pkg::qent_t             mem_q [itt_pkg::QDEPTH];
	logic [itt_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [itt_pkg::QPTR_W:0]   cnt_q;

	assign full  = cnt_q == (itt_pkg::QPTR_W+1)'(itt_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- design/itt_back.sv -----
// ----------------------------------------------------------------------------
// itt_back: token formatter
// Resolves keywords and integer types, finishes literal values and presents
// one token at a time in the output register.
// ----------------------------------------------------------------------------
module itt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 have,
	input  itt_pkg::qent_t       head,
	output logic                 pop,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output logic [6:0]           token_kind,
	output logic [31:0]          start_offset,
	output logic [31:0]          token_length,
	output logic [31:0]          token_line,
	output logic [31:0]          start_column,
	output logic signed [63:0]   integer_value,
	output logic [63:0]          hex_bits,
	output logic                 last_of_run
);

	logic        second_q, load, sel1, last;
	logic [6:0]  kind;
	logic [63:0] ival, hbits;
	logic [itt_pkg::KW_IDX_W-1:0] sh;
	logic [itt_pkg::KW_BITS-1:0]  key;
	itt_pkg::tok_full_t t0;

	assign t0   = head.t0;
	assign sel1 = second_q || !head.v0;
	assign last = sel1 || !head.v1;
	assign load = have && (!tok_valid || !tok_stall);
	assign pop  = load && last;

	assign sh  = itt_pkg::KW_IDX_W'(itt_pkg::MAX_KW) - t0.len[itt_pkg::KW_IDX_W-1:0];
	assign key = t0.word >> {sh, 3'b000};

	always_comb begin
		kind = t0.kind;
		if (t0.lookup) begin
			if (t0.len == '0 || t0.len > 32'(itt_pkg::MAX_KW))
				kind = itt_pkg::K_LOCAL;
			else
				kind = itt_pkg::kw_kind(key);
		end
		ival = '0;
		hbits = '0;
		if (t0.vclass == itt_pkg::VC_INT && t0.len < 32'(itt_pkg::LIT_LIMIT)) begin
			if (t0.neg)
				ival = (t0.acc >= itt_pkg::SAT_CAP) ? itt_pkg::SAT_CAP : 64'(-t0.acc);
			else
				ival = (t0.acc >= itt_pkg::SAT_CAP) ? itt_pkg::SAT_CAP - 64'd1 : t0.acc;
		end
		if (t0.vclass == itt_pkg::VC_HEX && t0.len >= 32'd2
			&& (t0.len - 32'd2) < 32'(itt_pkg::LIT_LIMIT))
			hbits = t0.acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			if (load) begin
				tok_valid <= 1'b1;
				second_q  <= !last;
			end else if (!tok_stall) begin
				tok_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_of_run <= last;
			if (sel1) begin
				token_kind    <= head.t1.kind;
				start_offset  <= head.t1.start;
				token_length  <= head.t1.len;
				token_line    <= head.t1.line;
				start_column  <= head.t1.col;
				integer_value <= '0;
				hex_bits      <= '0;
			end else begin
				token_kind    <= kind;
				start_offset  <= t0.start;
				token_length  <= t0.len;
				token_line    <= t0.line;
				start_column  <= t0.col;
				integer_value <= ival;
				hex_bits      <= hbits;
			end
		end
	end

endmodule
